// ===== sv/tkac_pkg.sv =====
package tkac_pkg;

   localparam int MaxClasses = 1024;
   localparam int ClassBits  = 10;
   localparam int CountBits  = 32;
   localparam int ScoreBits  = 32;

   localparam logic [1:0] REQ_SCORE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   localparam logic [1:0] CSR_TOP_K     = 2'd0;
   localparam logic [1:0] CSR_NUM_CLASS = 2'd1;
   localparam logic [1:0] CSR_IGN_EN    = 2'd2;
   localparam logic [1:0] CSR_IGN_LABEL = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TGT_RD,
      ST_TGT_WAIT,
      ST_SCAN,
      ST_CNT_RD,
      ST_CNT_WAIT,
      ST_RSP,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic                 kind;
      logic [ClassBits-1:0] pred;
      logic                 hit;
      logic                 skipped;
      logic                 bad;
      logic [CountBits-1:0] thits;
      logic [CountBits-1:0] tsamp;
      logic [CountBits-1:0] chits;
      logic [CountBits-1:0] csamp;
   } rsp_type;

   function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

endpackage

// ===== sv/tkac_score_mem.sv =====
module tkac_score_mem (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [tkac_pkg::ClassBits-1:0]         wr_addr,
   input  logic signed [tkac_pkg::ScoreBits-1:0]  wr_data,
   input  logic [tkac_pkg::ClassBits-1:0]         rd_addr,
   output logic signed [tkac_pkg::ScoreBits-1:0]  rd_data
);
   logic signed [tkac_pkg::ScoreBits-1:0] mem [tkac_pkg::MaxClasses];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/tkac_count_mem.sv =====
module tkac_count_mem (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [tkac_pkg::ClassBits-1:0]     wr_addr,
   input  logic [2*tkac_pkg::CountBits-1:0]   wr_data,
   input  logic [tkac_pkg::ClassBits-1:0]     rd_addr,
   output logic [2*tkac_pkg::CountBits-1:0]   rd_data
);
   // hits in the upper half, samples in the lower half
   logic [2*tkac_pkg::CountBits-1:0] mem [tkac_pkg::MaxClasses];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/top_k_accuracy_counter.sv =====
// Top-k accuracy counter.
// Input channel (req_*): one transaction per score element, counter read or
// counter clear. A sample is num_classes score transactions in class order;
// target_class is taken from the first one.
// Result channel (rsp_*): a verdict after the last score of a sample, or a
// counter readout after a read. Clear and score elements before the last
// produce nothing.
// Config (csr_*): register index and data; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// A score that does not end a sample is stored and the block stays idle. The
// final score starts a walk over the stored scores through the one-read score
// memory: TGT_RD, TGT_WAIT, SCAN, CNT_RD, CNT_WAIT, then RSP raises rsp_valid.
// A skipped sample goes from TGT_RD straight to RSP; a read goes through
// CNT_RD, CNT_WAIT and RSP. req_stall is high until the result is delivered.
// A clear, and reset, sweep the 1024-entry per-class counter memory one entry
// per cycle, with req_stall high throughout the sweep.
// When the receiver stalls, the result is held in rsp_* and no new
// transaction is taken until it is delivered.
module top_k_accuracy_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_req_type,
   input  logic signed [31:0]                    req_score,
   input  logic [15:0]                           req_target_class,
   input  logic [9:0]                            req_query_class,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_result_kind,
   output logic [9:0]                            rsp_predicted_class,
   output logic                                  rsp_hit,
   output logic                                  rsp_skipped,
   output logic                                  rsp_bad_target,
   output logic [31:0]                           rsp_total_hits,
   output logic [31:0]                           rsp_total_samples,
   output logic [31:0]                           rsp_class_hits,
   output logic [31:0]                           rsp_class_samples,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [31:0]                           csr_data
);
   localparam int CB = tkac_pkg::ClassBits;
   localparam int NB = tkac_pkg::CountBits;

   tkac_pkg::state_type state_ff, state_in;

   logic [10:0] top_k_ff, num_cls_ff;
   logic        ign_en_ff;
   logic [15:0] ign_lbl_ff;

   logic [CB-1:0]          idx_ff, idx_in;
   logic signed [31:0]     best_ff, best_in;
   logic [CB-1:0]          bcls_ff, bcls_in;
   logic [15:0]            tgt_ff, tgt_in;
   logic [10:0]            n_ff, n_in;          // classes in finished sample
   logic [CB-1:0]          scan_ff, scan_in;    // read address of walk
   logic [CB-1:0]          cmp_ff, cmp_in;      // index of data on rd_data
   logic                   cmpv_ff, cmpv_in;
   logic signed [31:0]     tscore_ff, tscore_in;
   logic [10:0]            rank_ff, rank_in;
   logic                   is_read_ff, is_read_in;
   logic [CB-1:0]          q_ff, q_in;
   logic [NB-1:0]          thits_ff, thits_in, tsamp_ff, tsamp_in;
   logic [CB-1:0]          clr_ff, clr_in;
   tkac_pkg::rsp_type      rsp_ff, rsp_in;
   logic                   rspv_ff, rspv_in;

   logic accept;
   logic [10:0] eff_n, n_now, kk;
   logic        sample_end;

   logic               smem_we;
   logic [CB-1:0]      smem_wa, smem_ra;
   logic signed [31:0] smem_rd;
   logic               cmem_we;
   logic [CB-1:0]      cmem_wa, cmem_ra;
   logic [2*NB-1:0]    cmem_wd, cmem_rd;

   tkac_score_mem u_score (
      .clock(clock), .wr_en(smem_we), .wr_addr(smem_wa), .wr_data(req_score),
      .rd_addr(smem_ra), .rd_data(smem_rd)
   );
   tkac_count_mem u_count (
      .clock(clock), .wr_en(cmem_we), .wr_addr(cmem_wa), .wr_data(cmem_wd),
      .rd_addr(cmem_ra), .rd_data(cmem_rd)
   );

   assign req_stall = (state_ff != tkac_pkg::ST_IDLE) || rspv_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      eff_n = num_cls_ff;
      if (num_cls_ff == 11'd0) begin
         eff_n = 11'd1;
      end else if (num_cls_ff > 11'(tkac_pkg::MaxClasses)) begin
         eff_n = 11'(tkac_pkg::MaxClasses);
      end
      n_now      = {1'b0, idx_ff} + 11'd1;
      sample_end = n_now >= eff_n;
      kk         = (top_k_ff > n_ff) ? n_ff : top_k_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tkac_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_req_type)
                  tkac_pkg::REQ_SCORE: begin
                     if (sample_end) state_in = tkac_pkg::ST_TGT_RD;
                  end
                  tkac_pkg::REQ_READ:  state_in = tkac_pkg::ST_CNT_RD;
                  tkac_pkg::REQ_CLEAR: state_in = tkac_pkg::ST_CLEAR;
                  default: ;
               endcase
            end
         end
         tkac_pkg::ST_TGT_RD: begin
            if ((ign_en_ff && tgt_ff == ign_lbl_ff) || ({5'd0, n_ff} <= tgt_ff)) begin
               state_in = tkac_pkg::ST_RSP;
            end else begin
               state_in = tkac_pkg::ST_TGT_WAIT;
            end
         end
         tkac_pkg::ST_TGT_WAIT: state_in = tkac_pkg::ST_SCAN;
         tkac_pkg::ST_SCAN: begin
            if (cmpv_ff && ({1'b0, cmp_ff} == n_ff - 11'd1)) state_in = tkac_pkg::ST_CNT_RD;
         end
         tkac_pkg::ST_CNT_RD:   state_in = tkac_pkg::ST_CNT_WAIT;
         tkac_pkg::ST_CNT_WAIT: state_in = tkac_pkg::ST_RSP;
         tkac_pkg::ST_RSP:      state_in = tkac_pkg::ST_IDLE;
         tkac_pkg::ST_CLEAR: begin
            if (&clr_ff) state_in = tkac_pkg::ST_IDLE;
         end
         default: state_in = tkac_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic hit_now;
      logic [NB-1:0] ch, cs;
      idx_in     = idx_ff;
      best_in    = best_ff;
      bcls_in    = bcls_ff;
      tgt_in     = tgt_ff;
      n_in       = n_ff;
      scan_in    = scan_ff;
      cmp_in     = cmp_ff;
      cmpv_in    = 1'b0;
      tscore_in  = tscore_ff;
      rank_in    = rank_ff;
      is_read_in = is_read_ff;
      q_in       = q_ff;
      thits_in   = thits_ff;
      tsamp_in   = tsamp_ff;
      clr_in     = clr_ff;
      rsp_in     = rsp_ff;
      rspv_in    = rspv_ff && rsp_stall;
      smem_we    = 1'b0;
      smem_wa    = idx_ff;
      smem_ra    = scan_ff;
      cmem_we    = 1'b0;
      cmem_wa    = q_ff;
      cmem_wd    = '0;
      cmem_ra    = q_ff;
      hit_now    = (rank_ff < kk);
      ch         = cmem_rd[2*NB-1:NB];
      cs         = cmem_rd[NB-1:0];

      case (state_ff)
         tkac_pkg::ST_IDLE: begin
            if (accept && req_req_type == tkac_pkg::REQ_SCORE) begin
               smem_we = 1'b1;
               if (idx_ff == '0) begin
                  tgt_in  = req_target_class;
                  best_in = req_score;
                  bcls_in = '0;
               end else if (req_score >= best_ff) begin
                  best_in = req_score;
                  bcls_in = idx_ff;
               end
               if (sample_end) begin
                  idx_in     = '0;
                  n_in       = n_now;
                  is_read_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (accept && req_req_type == tkac_pkg::REQ_READ) begin
               is_read_in = 1'b1;
               q_in       = req_query_class;
            end else if (accept && req_req_type == tkac_pkg::REQ_CLEAR) begin
               clr_in   = '0;
               thits_in = '0;
               tsamp_in = '0;
            end
         end
         tkac_pkg::ST_TGT_RD: begin
            smem_ra = tgt_ff[CB-1:0];
            q_in    = tgt_ff[CB-1:0];
            scan_in = '0;
            rank_in = '0;
            rsp_in  = '0;
            rsp_in.pred    = bcls_ff;
            rsp_in.skipped = 1'b1;
            rsp_in.bad     = !(ign_en_ff && tgt_ff == ign_lbl_ff);
            rsp_in.thits   = thits_ff;
            rsp_in.tsamp   = tsamp_ff;
         end
         tkac_pkg::ST_TGT_WAIT: begin
            smem_ra = '0;
            scan_in = 10'd1;
            cmp_in  = '0;
            cmpv_in = 1'b1;
         end
         tkac_pkg::ST_SCAN: begin
            smem_ra = scan_ff;
            scan_in = scan_ff + 1'b1;
            cmp_in  = cmp_ff + 1'b1;
            cmpv_in = 1'b1;
            if (cmpv_ff && cmp_ff != tgt_ff[CB-1:0]) begin
               if (smem_rd > tscore_ff || (smem_rd == tscore_ff && cmp_ff > tgt_ff[CB-1:0]))
                  rank_in = rank_ff + 1'b1;
            end
         end
         tkac_pkg::ST_CNT_RD: begin
            cmem_ra = q_ff;
         end
         tkac_pkg::ST_CNT_WAIT: begin
            rsp_in = '0;
            if (is_read_ff) begin
               rsp_in.kind  = 1'b1;
               rsp_in.thits = thits_ff;
               rsp_in.tsamp = tsamp_ff;
               rsp_in.chits = ch;
               rsp_in.csamp = cs;
            end else begin
               rsp_in.pred  = bcls_ff;
               rsp_in.hit   = hit_now;
               rsp_in.tsamp = tkac_pkg::sat_inc(tsamp_ff);
               rsp_in.csamp = tkac_pkg::sat_inc(cs);
               rsp_in.thits = hit_now ? tkac_pkg::sat_inc(thits_ff) : thits_ff;
               rsp_in.chits = hit_now ? tkac_pkg::sat_inc(ch) : ch;
               tsamp_in     = rsp_in.tsamp;
               thits_in     = rsp_in.thits;
               cmem_we      = 1'b1;
               cmem_wa      = q_ff;
               cmem_wd      = {rsp_in.chits, rsp_in.csamp};
            end
         end
         tkac_pkg::ST_RSP: begin
            rspv_in = 1'b1;
         end
         tkac_pkg::ST_CLEAR: begin
            cmem_we = 1'b1;
            cmem_wa = clr_ff;
            cmem_wd = '0;
            clr_in  = clr_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // target score arrives on the read port the cycle after TGT_RD
   logic signed [31:0] tscore_cap;
   assign tscore_cap = (state_ff == tkac_pkg::ST_TGT_WAIT) ? smem_rd : tscore_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tkac_pkg::ST_CLEAR;
         clr_ff     <= '0;
         rspv_ff    <= 1'b0;
         idx_ff     <= '0;
         best_ff    <= '0;
         bcls_ff    <= '0;
         tgt_ff     <= '0;
         thits_ff   <= '0;
         tsamp_ff   <= '0;
         cmpv_ff    <= 1'b0;
         top_k_ff   <= 11'd1;
         num_cls_ff <= 11'd1024;
         ign_en_ff  <= 1'b0;
         ign_lbl_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rspv_ff  <= rspv_in;
         idx_ff   <= idx_in;
         best_ff  <= best_in;
         bcls_ff  <= bcls_in;
         tgt_ff   <= tgt_in;
         thits_ff <= thits_in;
         tsamp_ff <= tsamp_in;
         cmpv_ff  <= cmpv_in;
         if (csr_valid) begin
            case (csr_index)
               tkac_pkg::CSR_TOP_K:     top_k_ff   <= csr_data[10:0];
               tkac_pkg::CSR_NUM_CLASS: num_cls_ff <= csr_data[10:0];
               tkac_pkg::CSR_IGN_EN:    ign_en_ff  <= csr_data[0];
               tkac_pkg::CSR_IGN_LABEL: ign_lbl_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      scan_ff    <= scan_in;
      cmp_ff     <= cmp_in;
      tscore_ff  <= tscore_cap;
      rank_ff    <= rank_in;
      is_read_ff <= is_read_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid           = rspv_ff;
   assign rsp_result_kind     = rsp_ff.kind;
   assign rsp_predicted_class = rsp_ff.pred;
   assign rsp_hit             = rsp_ff.hit;
   assign rsp_skipped         = rsp_ff.skipped;
   assign rsp_bad_target      = rsp_ff.bad;
   assign rsp_total_hits      = rsp_ff.thits;
   assign rsp_total_samples   = rsp_ff.tsamp;
   assign rsp_class_hits      = rsp_ff.chits;
   assign rsp_class_samples   = rsp_ff.csamp;
endmodule

// ===== sv/tkac_checker.sv =====
module tkac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic        rsp_hit,
   input logic        rsp_skipped,
   input logic        rsp_bad_target,
   input logic [31:0] rsp_class_hits,
   input logic [31:0] rsp_class_samples
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_class_hits))
      else $error("result changed under stall");
   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_hit_not_skipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_skipped))
      else $error("skipped sample flagged as hit");
   a_bad_implies_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_target |-> rsp_skipped && !rsp_result_kind)
      else $error("bad target without skip");
   a_hits_le_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && !rsp_skipped |-> rsp_class_hits <= rsp_class_samples)
      else $error("class hits exceed samples");
endmodule

bind top_k_accuracy_counter tkac_checker u_tkac_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_kind(rsp_result_kind),
   .rsp_hit(rsp_hit), .rsp_skipped(rsp_skipped), .rsp_bad_target(rsp_bad_target),
   .rsp_class_hits(rsp_class_hits), .rsp_class_samples(rsp_class_samples)
);

// ===== test/tb_top_k_accuracy_counter.sv =====
`timescale 1ns / 1ps

module tb_top_k_accuracy_counter;

   localparam int HalfPeriod = 6;
   localparam int IdleLimit  = 20000;   // cycles without any transaction
   localparam int SweepWait  = 1100;    // covers the 1024-entry counter sweep
   localparam int ItemGoal   = 1500;
   localparam int MaxClasses = tkac_pkg::MaxClasses;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_req_type;
   logic signed [31:0]  req_score;
   logic [15:0]         req_target_class;
   logic [9:0]          req_query_class;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_result_kind;
   logic [9:0]          rsp_predicted_class;
   logic                rsp_hit;
   logic                rsp_skipped;
   logic                rsp_bad_target;
   logic [31:0]         rsp_total_hits;
   logic [31:0]         rsp_total_samples;
   logic [31:0]         rsp_class_hits;
   logic [31:0]         rsp_class_samples;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [31:0]         csr_data;

   top_k_accuracy_counter dut (.*);

   // Mirror of the block: configuration, sample in flight and counters.
   logic [10:0]        k_cfg;
   logic [10:0]        classes_cfg;
   logic               ign_en_cfg;
   logic [15:0]        ign_label_cfg;
   logic signed [31:0] sample_scores [MaxClasses];
   int unsigned        elem_pos;
   logic signed [31:0] lead_score;
   logic [9:0]         lead_class;
   logic [15:0]        cur_target;
   logic [31:0]        hits_all;
   logic [31:0]        samples_all;
   logic [31:0]        hits_per_class [MaxClasses];
   logic [31:0]        samples_per_class [MaxClasses];

   tkac_pkg::rsp_type verdict_q[$];
   int          err_count;
   int          items_sent;
   int          burst_left;
   int          quiet_cycles;
   int unsigned stall_tick;
   int          stall_mode;

   always #HalfPeriod clock = ~clock;

   function automatic int unsigned active_classes();
      if (classes_cfg == 11'd0) return 1;
      if (classes_cfg > 11'(MaxClasses)) return MaxClasses;
      return 32'(classes_cfg);
   endfunction

   // Work out what one accepted transaction produces; returns 1 when a result
   // is due.
   function automatic bit score_transaction(input logic [1:0] rt,
                                            input logic signed [31:0] sc,
                                            input logic [15:0] tg,
                                            input logic [9:0] qc,
                                            output tkac_pkg::rsp_type r);
      int unsigned idx;
      int unsigned n;
      int unsigned kk;
      int unsigned rank;
      int unsigned t;
      bit          hit;
      r = '0;
      hit = 0;
      rank = 0;
      if (rt == tkac_pkg::REQ_CLEAR) begin
         hits_all = '0;
         samples_all = '0;
         for (int c = 0; c < MaxClasses; c++) begin
            hits_per_class[c] = '0;
            samples_per_class[c] = '0;
         end
         return 0;
      end
      if (rt == tkac_pkg::REQ_READ) begin
         r.kind  = 1'b1;
         r.thits = hits_all;
         r.tsamp = samples_all;
         r.chits = hits_per_class[qc];
         r.csamp = samples_per_class[qc];
         return 1;
      end
      if (rt != tkac_pkg::REQ_SCORE) return 0;

      idx = (elem_pos >= MaxClasses) ? MaxClasses - 1 : elem_pos;
      if (idx == 0) begin
         cur_target = tg;
         lead_score = sc;
         lead_class = '0;
      end else if (sc >= lead_score) begin
         lead_score = sc;
         lead_class = idx[9:0];
      end
      sample_scores[idx] = sc;
      n = idx + 1;
      if (n < active_classes()) begin
         elem_pos = n;
         return 0;
      end
      elem_pos = 0;

      t = 32'(cur_target);
      kk = (32'(k_cfg) > n) ? n : 32'(k_cfg);
      r.pred = lead_class;
      if (ign_en_cfg && cur_target == ign_label_cfg) begin
         r.skipped = 1'b1;
      end else if (t >= n) begin
         r.skipped = 1'b1;
         r.bad = 1'b1;
      end else begin
         // ties rank the higher class index first
         for (int unsigned c = 0; c < n; c++) begin
            if (c != t && (sample_scores[c] > sample_scores[t] ||
                           (sample_scores[c] == sample_scores[t] && c > t)))
               rank++;
         end
         hit = rank < kk;
         if (!(&samples_all)) samples_all++;
         if (!(&samples_per_class[t])) samples_per_class[t]++;
         if (hit) begin
            if (!(&hits_all)) hits_all++;
            if (!(&hits_per_class[t])) hits_per_class[t]++;
         end
         r.chits = hits_per_class[t];
         r.csamp = samples_per_class[t];
      end
      r.hit = hit;
      r.thits = hits_all;
      r.tsamp = samples_all;
      return 1;
   endfunction

   // Send one transaction; the sender works in bursts with random gaps.
   task automatic send_req(input logic [1:0] rt, input logic signed [31:0] sc,
                           input logic [15:0] tg, input logic [9:0] qc);
      tkac_pkg::rsp_type r;
      int      gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_req_type     <= rt;
      req_score        <= sc;
      req_target_class <= tg;
      req_query_class  <= qc;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      if (score_transaction(rt, sc, tg, qc, r)) verdict_q = {verdict_q, r};
      if (rt != tkac_pkg::REQ_NONE) items_sent++;
   endtask

   // Hold off until every result is in and the block has gone quiet.
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SweepWait) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tkac_pkg::CSR_TOP_K:     k_cfg = value[10:0];
         tkac_pkg::CSR_NUM_CLASS: classes_cfg = value[10:0];
         tkac_pkg::CSR_IGN_EN:    ign_en_cfg = value[0];
         tkac_pkg::CSR_IGN_LABEL: ign_label_cfg = value[15:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int k, input int n, input bit en, input int label);
      settle();
      csr_write(tkac_pkg::CSR_TOP_K, {11'($urandom_range(0, 2047)), 21'(k)});
      csr_write(tkac_pkg::CSR_NUM_CLASS, {11'($urandom_range(0, 2047)), 21'(n)});
      csr_write(tkac_pkg::CSR_IGN_EN, {16'($urandom_range(0, 65535)), 16'(en)});
      csr_write(tkac_pkg::CSR_IGN_LABEL, {16'($urandom()), 16'(label)});
   endtask

   function automatic logic signed [31:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3, 4: return $signed(32'($urandom_range(0, 6))) - 3;
         default: return $signed($urandom());
      endcase
   endfunction

   // Complete the sample in flight, with a random target; occasionally
   // slip a read, clear or unknown request in between elements.
   task automatic random_sample();
      int unsigned n;
      logic [15:0] tg;
      n = active_classes();
      case ($urandom_range(0, 9))
         0:       tg = ign_label_cfg;
         1:       tg = 16'($urandom());
         2:       tg = 16'(n);
         3:       tg = 16'(n - 1);
         default: tg = 16'($urandom_range(0, n - 1));
      endcase
      for (int unsigned e = elem_pos; e < n; e++) begin
         if ($urandom_range(0, 39) == 0)
            send_req(2'($urandom_range(1, 3)), $signed($urandom()), 16'($urandom()),
                     10'($urandom()));
         send_req(tkac_pkg::REQ_SCORE, pick_score(), tg, 10'($urandom()));
      end
   endtask

   task automatic test_ties_and_extremes();
      set_config(2, 4, 0, 0);
      send_req(tkac_pkg::REQ_SCORE, 32'sh7fffffff, 16'd0, 10'd0);
      send_req(tkac_pkg::REQ_SCORE, 32'sh80000000, 16'd0, 10'd0);
      send_req(tkac_pkg::REQ_SCORE, 32'sh7fffffff, 16'd0, 10'd0);
      send_req(tkac_pkg::REQ_SCORE, 32'sh00000000, 16'd0, 10'd0);
      for (int e = 0; e < 4; e++) send_req(tkac_pkg::REQ_SCORE, -32'sd5, 16'd3, 10'h3ff);
      for (int e = 0; e < 4; e++) send_req(tkac_pkg::REQ_SCORE, -32'sd5, 16'd0, 10'h3ff);
   endtask

   task automatic test_skips();
      set_config(1, 3, 1, 1);
      for (int e = 0; e < 3; e++) send_req(tkac_pkg::REQ_SCORE, e, 16'd1, 10'd0);
      for (int e = 0; e < 3; e++) send_req(tkac_pkg::REQ_SCORE, e, 16'd3, 10'd0);
      for (int e = 0; e < 3; e++) send_req(tkac_pkg::REQ_SCORE, e, 16'hffff, 10'd0);
   endtask

   task automatic test_top_k_zero();
      set_config(0, 2, 0, 16'hffff);
      send_req(tkac_pkg::REQ_SCORE, 32'sd1, 16'd1, 10'd0);
      send_req(tkac_pkg::REQ_SCORE, 32'sd0, 16'd1, 10'd0);
   endtask

   task automatic test_read_and_clear();
      send_req(tkac_pkg::REQ_READ, 32'sd0, 16'd0, 10'd1);
      send_req(tkac_pkg::REQ_READ, 32'sd0, 16'd0, 10'h3ff);
      send_req(tkac_pkg::REQ_NONE, 32'sd0, 16'd0, 10'd0);
      send_req(tkac_pkg::REQ_CLEAR, 32'sd0, 16'd0, 10'd0);
      send_req(tkac_pkg::REQ_READ, 32'sd0, 16'd0, 10'd0);
   endtask

   // Shrink the class count in the middle of a sample: it ends at the next element.
   task automatic test_shrink_mid_sample();
      set_config(2, 5, 0, 0);
      for (int e = 0; e < 3; e++) send_req(tkac_pkg::REQ_SCORE, 10 - e, 16'd2, 10'd0);
      send_req(tkac_pkg::REQ_CLEAR, 32'sd0, 16'd0, 10'd0);
      settle();
      csr_write(tkac_pkg::CSR_NUM_CLASS, 32'd2);
      send_req(tkac_pkg::REQ_SCORE, 32'sd10, 16'd2, 10'd0);
      send_req(tkac_pkg::REQ_READ, 32'sd0, 16'd0, 10'd2);
   endtask

   task automatic test_random();
      int n;
      int phase_goal;
      for (int p = 0; items_sent < ItemGoal; p++) begin
         case (p % 8)
            2:       n = 0;
            4:       n = (p < 8) ? 1024 : 1;
            6:       n = (p < 8) ? 2047 : $urandom_range(20, 60);
            default: n = $urandom_range(2, 12);
         endcase
         set_config((p % 5 == 0) ? 2047 : $urandom_range(0, 5), n, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom());
         phase_goal = items_sent + ((n > 100) ? 1 : 150);
         while (items_sent < phase_goal) random_sample();
         if ($urandom_range(0, 1) != 0)
            send_req(tkac_pkg::REQ_CLEAR, $signed($urandom()), 16'($urandom()),
                     10'($urandom()));
      end
   endtask

   // Receiver stalls on a pattern of its own: free, light, heavy and long runs.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) != 0);
         default: rsp_stall <= stall_tick[4];
      endcase
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endtask

   // Compare each delivered result with the oldest expectation.
   always @(posedge clock) begin
      tkac_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("result transaction with nothing expected");
            err_count++;
         end else begin
            want = verdict_q.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
            check_field("predicted_class", 32'(want.pred), 32'(rsp_predicted_class));
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("skipped", 32'(want.skipped), 32'(rsp_skipped));
            check_field("bad_target", 32'(want.bad), 32'(rsp_bad_target));
            check_field("total_hits", want.thits, rsp_total_hits);
            check_field("total_samples", want.tsamp, rsp_total_samples);
            check_field("class_hits", want.chits, rsp_class_hits);
            check_field("class_samples", want.csamp, rsp_class_samples);
         end
      end
   end

   // Watchdog: end the run after too long without any transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("** top_k_accuracy_counter: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_req_type = tkac_pkg::REQ_SCORE;
      req_score = '0;
      req_target_class = '0;
      req_query_class = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = tkac_pkg::CSR_TOP_K;
      csr_data = '0;
      err_count = 0;
      items_sent = 0;
      burst_left = 0;
      quiet_cycles = 0;
      stall_tick = 0;
      stall_mode = 0;
      k_cfg = 11'd1;
      classes_cfg = 11'd1024;
      ign_en_cfg = 1'b0;
      ign_label_cfg = '0;
      elem_pos = 0;
      lead_score = '0;
      lead_class = '0;
      cur_target = '0;
      hits_all = '0;
      samples_all = '0;
      for (int c = 0; c < MaxClasses; c++) begin
         sample_scores[c] = '0;
         hits_per_class[c] = '0;
         samples_per_class[c] = '0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_ties_and_extremes();
      test_skips();
      test_top_k_zero();
      test_read_and_clear();
      test_shrink_mid_sample();
      test_random();

      // drain, then give the block time for anything left over
      settle();
      repeat (50) @(posedge clock);
      if (err_count == 0)
         $display("** top_k_accuracy_counter: PASSED **");
      else
         $display("** top_k_accuracy_counter: FAILED **");
      $finish;
   end

endmodule
